// ===== sv/ccs_pkg.sv =====
// ----------------------------------------------------------------------------
// ccs_pkg: shared types and constants for the ChaCha byte stream cipher
// State matrix constants, config register indexes, queue entry type.
// ----------------------------------------------------------------------------
package ccs_pkg;

  localparam logic [31:0] SIGMA0 = 32'h61707865;
  localparam logic [31:0] SIGMA1 = 32'h3320646E;
  localparam logic [31:0] SIGMA2 = 32'h79622D32;
  localparam logic [31:0] SIGMA3 = 32'h6B206574;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_A  = 3'd0,
    REG_KEY_B  = 3'd1,
    REG_KEY_C  = 3'd2,
    REG_KEY_D  = 3'd3,
    REG_NONCE  = 3'd4,
    REG_DROUND = 3'd5
  } reg_idx_t;

  // Item handed from the front end to the keystream engine.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } q_item_t;

  typedef enum logic [1:0] {
    ENG_IDLE,
    ENG_ROUND,
    ENG_FINAL,
    ENG_XOR
  } eng_state_t;

  typedef logic [31:0] word_t;

  function automatic word_t rotl(input word_t v, input int n);
    rotl = (v << n) | (v >> (32 - n));
  endfunction

  // One quarter-round on four words, returned as {a,b,c,d}.
  function automatic logic [127:0] qround(input word_t a, input word_t b,
                                          input word_t c, input word_t d);
    word_t ta, tb, tc, td;
    ta = a + b;   td = rotl(d ^ ta, 16);
    tc = c + td;  tb = rotl(b ^ tc, 12);
    ta = ta + tb; td = rotl(td ^ ta, 8);
    tc = tc + td; tb = rotl(tb ^ tc, 7);
    qround = {ta, tb, tc, td};
  endfunction

endpackage

// ===== sv/ccs_stream_if.sv =====
// ----------------------------------------------------------------------------
// ccs_stream_if: valid/ready channel carrying a byte and a last flag
// ----------------------------------------------------------------------------
interface ccs_stream_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_of_message;

  modport source (output valid, output data_byte, output last_of_message,
                  input ready);
  modport sink   (input valid, input data_byte, input last_of_message,
                  output ready);
endinterface

// ===== sv/ccs_result_if.sv =====
// ----------------------------------------------------------------------------
// ccs_result_if: valid/ready channel carrying a result byte and last flag
// ----------------------------------------------------------------------------
interface ccs_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] result_byte;
  logic       result_last;

  modport source (output valid, output result_byte, output result_last,
                  input ready);
  modport sink   (input valid, input result_byte, input result_last,
                  output ready);
endinterface

// ===== sv/ccs_cfg_if.sv =====
// ----------------------------------------------------------------------------
// ccs_cfg_if: register write channel, index and 64-bit data
// ----------------------------------------------------------------------------
interface ccs_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/ccs_front.sv =====
// ----------------------------------------------------------------------------
// ccs_front: input item queue
// Two-entry FIFO between the input channel and the keystream engine.
// ----------------------------------------------------------------------------
module ccs_front
  import ccs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  ccs_stream_if.sink in_ch,
  output logic       q_valid,
  output q_item_t    q_item,
  input  logic       q_pop
);
  q_item_t    mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign in_ch.ready = (count != 2'd2);
  assign push = in_ch.valid && in_ch.ready;
  assign q_valid = (count != 2'd0);
  assign pop = q_pop && q_valid;
  assign q_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= '{data: in_ch.data_byte, last: in_ch.last_of_message};
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// ===== sv/ccs_engine.sv =====
// ----------------------------------------------------------------------------
// ccs_engine: keystream block generator and byte combiner
// Four quarter-rounds per cycle, one output register for results.
// ----------------------------------------------------------------------------
module ccs_engine
  import ccs_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         q_valid,
  input  q_item_t      q_item,
  output logic         q_pop,
  input  logic [255:0] key,
  input  logic [63:0]  nonce,
  input  logic [7:0]   double_rounds,
  ccs_result_if.source out_ch
);
  eng_state_t state, state_next;
  word_t      w [16];
  word_t      m [16];
  word_t      ks [16];
  logic [63:0] block_counter;
  logic [6:0]  byte_position;
  logic [7:0]  dr_left;
  logic        diag;
  logic        need_block;
  logic        out_free;
  logic [5:0]  p;
  logic [31:0] ks_word;
  logic [7:0]  ks_byte;
  word_t       rnd [16];
  logic [127:0] q0, q1, q2, q3;

  assign need_block = (byte_position == 7'd0) || (byte_position >= 7'd64);
  assign out_free = !out_ch.valid || out_ch.ready;
  assign p = need_block ? 6'd0 : byte_position[5:0];
  assign ks_word = ks[p[5:2]];
  assign ks_byte = 8'(ks_word >> {p[1:0], 3'b000});

  always_comb begin
    m[0] = SIGMA0; m[1] = SIGMA1; m[2] = SIGMA2; m[3] = SIGMA3;
    for (int i = 0; i < 8; i++) m[4+i] = key[32*i +: 32];
    m[12] = block_counter[31:0];
    m[13] = block_counter[63:32];
    m[14] = nonce[31:0];
    m[15] = nonce[63:32];
  end

  // Column or diagonal half-round.
  always_comb begin
    if (!diag) begin
      q0 = qround(w[0], w[4], w[8],  w[12]);
      q1 = qround(w[1], w[5], w[9],  w[13]);
      q2 = qround(w[2], w[6], w[10], w[14]);
      q3 = qround(w[3], w[7], w[11], w[15]);
      {rnd[0], rnd[4], rnd[8],  rnd[12]} = q0;
      {rnd[1], rnd[5], rnd[9],  rnd[13]} = q1;
      {rnd[2], rnd[6], rnd[10], rnd[14]} = q2;
      {rnd[3], rnd[7], rnd[11], rnd[15]} = q3;
    end else begin
      q0 = qround(w[0], w[5], w[10], w[15]);
      q1 = qround(w[1], w[6], w[11], w[12]);
      q2 = qround(w[2], w[7], w[8],  w[13]);
      q3 = qround(w[3], w[4], w[9],  w[14]);
      {rnd[0], rnd[5], rnd[10], rnd[15]} = q0;
      {rnd[1], rnd[6], rnd[11], rnd[12]} = q1;
      {rnd[2], rnd[7], rnd[8],  rnd[13]} = q2;
      {rnd[3], rnd[4], rnd[9],  rnd[14]} = q3;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ENG_IDLE: if (q_valid) state_next = need_block ? ENG_ROUND : ENG_XOR;
      ENG_ROUND: if (dr_left == 8'd0 && !diag) state_next = ENG_FINAL;
      ENG_FINAL: state_next = ENG_XOR;
      ENG_XOR: if (out_free) state_next = ENG_IDLE;
      default: state_next = ENG_IDLE;
    endcase
  end

  always_comb begin
    q_pop = (state == ENG_XOR) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ENG_IDLE;
      block_counter <= '0;
      byte_position <= '0;
      out_ch.valid <= 1'b0;
      diag <= 1'b0;
      dr_left <= '0;
    end else begin
      state <= state_next;
      if (out_ch.valid && out_ch.ready && !q_pop) out_ch.valid <= 1'b0;
      unique case (state)
        ENG_IDLE: begin
          if (q_valid && need_block) begin
            for (int i = 0; i < 16; i++) w[i] <= m[i];
            dr_left <= double_rounds;
            diag <= 1'b0;
          end
        end
        ENG_ROUND: begin
          if (!(dr_left == 8'd0 && !diag)) begin
            for (int i = 0; i < 16; i++) w[i] <= rnd[i];
            diag <= ~diag;
            if (diag) dr_left <= dr_left - 8'd1;
          end
        end
        ENG_FINAL: begin
          for (int i = 0; i < 16; i++) ks[i] <= w[i] + m[i];
          block_counter <= block_counter + 64'd1;
          byte_position <= 7'd0;
        end
        ENG_XOR: begin
          if (out_free) begin
            out_ch.valid <= 1'b1;
            out_ch.result_byte <= q_item.data ^ ks_byte;
            out_ch.result_last <= q_item.last;
            if (q_item.last) begin
              block_counter <= '0;
              byte_position <= '0;
            end else begin
              byte_position <= {1'b0, p} + 7'd1;
            end
          end
        end
        default: ;
      endcase
    end
  end
endmodule

// ===== sv/chacha_stream_cipher.sv =====
// ----------------------------------------------------------------------------
// chacha_stream_cipher: ChaCha byte stream cipher, 64-bit nonce and counter
// Same operation encrypts and decrypts; keystream restarts after a last byte.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                        | handshake
//  in_ch    | in  | data_byte, last_of_message     | valid/ready
//  out_ch   | out | result_byte, result_last       | valid/ready
//  cfg_ch   | in  | index (3b), data (64b)         | valid/ready, always ready
//
// A byte inside a ready block passes through queue pop and XOR into output reg.
// A byte that opens a block first runs the ROUND and FINAL states: the round
// unit does four quarter-rounds per cycle.
// Synchronous reset clears counter, position, queue and handshakes; the
// registers go to zero key/nonce and 50 double rounds.
// The input queue accepts up to two items while the output reg is stalled.
// ----------------------------------------------------------------------------
module chacha_stream_cipher
  import ccs_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  ccs_stream_if.sink   in_ch,
  ccs_result_if.source out_ch,
  ccs_cfg_if.sink      cfg_ch
);
  logic [255:0] key;
  logic [63:0]  nonce;
  logic [7:0]   double_rounds;
  logic         q_valid;
  logic         q_pop;
  q_item_t      q_item;

  assign cfg_ch.ready = 1'b1;

  // Config registers; writes outside the list fall through unused.
  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
      nonce <= '0;
      double_rounds <= 8'd50;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_KEY_A:  key[63:0]    <= cfg_ch.data;
        REG_KEY_B:  key[127:64]  <= cfg_ch.data;
        REG_KEY_C:  key[191:128] <= cfg_ch.data;
        REG_KEY_D:  key[255:192] <= cfg_ch.data;
        REG_NONCE:  nonce        <= cfg_ch.data;
        REG_DROUND: double_rounds <= cfg_ch.data[7:0];
        default: ;
      endcase
    end
  end

  ccs_front u_front (
    .clk(clk), .rst(rst), .in_ch(in_ch),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
  );

  ccs_engine u_engine (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
    .key(key), .nonce(nonce), .double_rounds(double_rounds), .out_ch(out_ch)
  );
endmodule
